>>> rtl/core/drive_init_sequencer_unit_defines.svh
// assertion macros for the drive start-up sequencer
`ifndef DRIVE_INIT_SEQUENCER_UNIT_DEFINES_SVH
`define DRIVE_INIT_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define DIS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("drive init sequencer check failed");
// condition that must be followed in the next cycle by a consequence
`define DIS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("drive init sequencer check failed");
`else
`define DIS_ASSERT(lbl, clk, rstn, prop)
`define DIS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

>>> rtl/core/dis_pkg.sv
// types and constants shared by the drive start-up sequencer
`default_nettype none
package dis_pkg;

  // sequence phases
  typedef enum logic [3:0] {
    PhReady     = 4'd0,
    PhDisable   = 4'd1,
    PhTx        = 4'd2,
    PhUndisable = 4'd3,
    PhAcc       = 4'd4,
    PhDec       = 4'd5,
    PhClear     = 4'd6,
    PhDone      = 4'd7,
    PhError     = 4'd8
  } phase_e;

  // input opcodes
  typedef enum logic {
    OpStep    = 1'b0,
    OpRestart = 1'b1
  } opcode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgActionInterval = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeout        = 8'd1;

  // configuration reset values
  localparam logic [CfgDataW-1:0] ActionIntervalRst = 16'd101;
  localparam logic [CfgDataW-1:0] TimeoutRst        = 16'd2000;

  // command frame bytes
  localparam logic [7:0] CmdRegRead     = 8'h3D;
  localparam logic [7:0] CmdRegMode     = 8'h51;
  localparam logic [7:0] CmdRegAcc      = 8'h35;
  localparam logic [7:0] CmdRegDec      = 8'hED;
  localparam logic [7:0] CmdRegClearErr = 8'h8E;
  localparam logic [7:0] RdReadyStatus  = 8'hE2;
  localparam logic [7:0] RdTxEnable     = 8'hE8;
  localparam logic [7:0] ModeDisable    = 8'h04;
  localparam logic [7:0] AccRampLow     = 8'hF4;
  localparam logic [7:0] AccRampHigh    = 8'h01;
  localparam logic [7:0] DecRampLow     = 8'hE8;
  localparam logic [7:0] DecRampHigh    = 8'h03;

  typedef struct packed {
    logic [CfgDataW-1:0] action_interval_ms;
    logic [CfgDataW-1:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] now_ms;
    logic        ready_ack;
    logic        transmit_ack;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] phase_start_ms;
    logic [31:0] last_send_ms;
    logic        undisable_sent;
  } state_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] cmd_register;
    logic [7:0] cmd_data_low;
    logic [7:0] cmd_data_high;
    logic       initialized;
    logic       failed;
    logic [3:0] phase_now;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/dis_if.sv
// handshake channels of the drive start-up sequencer
`default_nettype none
interface dis_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now_ms;
  logic        ready_ack;
  logic        transmit_ack;

  modport source (output valid, opcode, now_ms, ready_ack, transmit_ack, input ready);
  modport sink (input valid, opcode, now_ms, ready_ack, transmit_ack, output ready);
endinterface

interface dis_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] cmd_register;
  logic [7:0] cmd_data_low;
  logic [7:0] cmd_data_high;
  logic       initialized;
  logic       failed;
  logic [3:0] phase_now;

  modport source (output valid, send_valid, cmd_register, cmd_data_low, cmd_data_high,
                  initialized, failed, phase_now, input ready);
  modport sink (input valid, send_valid, cmd_register, cmd_data_low, cmd_data_high,
                initialized, failed, phase_now, output ready);
endinterface

interface dis_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dis_pkg::CfgIdxW-1:0]  index;
  logic [dis_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dis_cfg.sv
// configuration registers of the drive start-up sequencer
`default_nettype none
module dis_cfg (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dis_cfg_if.sink      cfg_i,
  output dis_pkg::cfg_t cfg_o
);

  logic [dis_pkg::CfgDataW-1:0] action_interval_q;
  logic [dis_pkg::CfgDataW-1:0] timeout_q;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register write decode, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_interval_q <= dis_pkg::ActionIntervalRst;
      timeout_q         <= dis_pkg::TimeoutRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dis_pkg::CfgActionInterval: action_interval_q <= cfg_i.data;
        dis_pkg::CfgTimeout:        timeout_q         <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o.action_interval_ms = action_interval_q;
  assign cfg_o.timeout_ms         = timeout_q;

endmodule
`default_nettype wire

>>> rtl/core/dis_step.sv
// one sequencer step: next state and result frame from the current state
`default_nettype none
module dis_step (
  input  wire dis_pkg::cfg_t    cfg_i,
  input  wire dis_pkg::state_t  state_i,
  input  wire dis_pkg::item_t   item_i,
  output dis_pkg::state_t  state_o,
  output dis_pkg::result_t result_o
);

  logic [31:0] since_send;
  logic [31:0] since_start;
  logic        poll_due;
  logic        timed_out;
  logic        send;
  logic [7:0]  b_reg;
  logic [7:0]  b_low;
  logic [7:0]  b_high;
  logic        init_flag;
  dis_pkg::state_t nxt;

  // wrap-around time differences
  assign since_send  = item_i.now_ms - state_i.last_send_ms;
  assign since_start = item_i.now_ms - state_i.phase_start_ms;
  assign poll_due    = since_send >= {16'd0, cfg_i.action_interval_ms};
  assign timed_out   = since_start >= {16'd0, cfg_i.timeout_ms};

  // phase transitions and frame selection
  always_comb begin
    nxt       = state_i;
    send      = 1'b0;
    b_reg     = 8'd0;
    b_low     = 8'd0;
    b_high    = 8'd0;
    init_flag = 1'b0;
    if (item_i.opcode == dis_pkg::OpRestart) begin
      nxt.phase          = dis_pkg::PhReady;
      nxt.phase_start_ms = item_i.now_ms;
      nxt.last_send_ms   = 32'd0;
      nxt.undisable_sent = 1'b0;
    end else begin
      case (state_i.phase)
        dis_pkg::PhReady: begin
          if (poll_due) begin
            send             = 1'b1;
            b_reg            = dis_pkg::CmdRegRead;
            b_low            = dis_pkg::RdReadyStatus;
            nxt.last_send_ms = item_i.now_ms;
          end
          if (item_i.ready_ack) begin
            nxt.phase          = dis_pkg::PhDisable;
            nxt.undisable_sent = 1'b0;
          end else if (timed_out) begin
            nxt.phase = dis_pkg::PhError;
          end
        end
        dis_pkg::PhDisable: begin
          send      = 1'b1;
          b_reg     = dis_pkg::CmdRegMode;
          b_low     = dis_pkg::ModeDisable;
          nxt.phase = dis_pkg::PhTx;
        end
        dis_pkg::PhTx: begin
          if (poll_due) begin
            send             = 1'b1;
            b_reg            = dis_pkg::CmdRegRead;
            b_low            = dis_pkg::RdTxEnable;
            nxt.last_send_ms = item_i.now_ms;
          end
          if (item_i.transmit_ack) begin
            nxt.phase          = dis_pkg::PhUndisable;
            nxt.undisable_sent = 1'b0;
            nxt.phase_start_ms = item_i.now_ms;
            nxt.last_send_ms   = item_i.now_ms;
          end else if (timed_out) begin
            nxt.phase = dis_pkg::PhError;
          end
        end
        dis_pkg::PhUndisable: begin
          // the frame is sent once and the step moves on to PhAcc; with the flag set it idles here
          if (!state_i.undisable_sent) begin
            send               = 1'b1;
            b_reg              = dis_pkg::CmdRegMode;
            nxt.undisable_sent = 1'b1;
            nxt.phase          = dis_pkg::PhAcc;
          end
        end
        dis_pkg::PhAcc: begin
          send      = 1'b1;
          b_reg     = dis_pkg::CmdRegAcc;
          b_low     = dis_pkg::AccRampLow;
          b_high    = dis_pkg::AccRampHigh;
          nxt.phase = dis_pkg::PhDec;
        end
        dis_pkg::PhDec: begin
          send      = 1'b1;
          b_reg     = dis_pkg::CmdRegDec;
          b_low     = dis_pkg::DecRampLow;
          b_high    = dis_pkg::DecRampHigh;
          nxt.phase = dis_pkg::PhClear;
        end
        dis_pkg::PhClear: begin
          send      = 1'b1;
          b_reg     = dis_pkg::CmdRegClearErr;
          nxt.phase = dis_pkg::PhDone;
        end
        dis_pkg::PhDone: begin
          init_flag = 1'b1;
        end
        dis_pkg::PhError: ;
        default: begin
          nxt.phase = dis_pkg::PhError;
        end
      endcase
    end
  end

  assign state_o = nxt;

  // result item
  assign result_o.send_valid    = send;
  assign result_o.cmd_register  = b_reg;
  assign result_o.cmd_data_low  = b_low;
  assign result_o.cmd_data_high = b_high;
  assign result_o.initialized   = init_flag;
  assign result_o.failed        = (nxt.phase == dis_pkg::PhError);
  assign result_o.phase_now     = nxt.phase;

endmodule
`default_nettype wire

>>> rtl/core/drive_init_sequencer_unit.sv
// top level of the drive start-up sequencer
//
//  port    dir  role
//  in_i    in   step items: opcode, now_ms, ready_ack, transmit_ack
//  out_o   out  result items: command frame, initialized, failed, phase_now
//  cfg_i   in   register writes: index, data
//
// one item per cycle sustained while the output is taken; each item waits in the input
// register until the output register is free or taken, then moves into it.
// a result becomes valid when its item leaves the input register and stays valid
// until it is taken.
// the sequencer state is updated when an item moves to the output register.
// reset returns the sequence to the ready poll and the registers to defaults.
// a stalled output holds the result and the input register in place.
`default_nettype none
`include "drive_init_sequencer_unit_defines.svh"
module drive_init_sequencer_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dis_in_if.sink    in_i,
  dis_out_if.source out_o,
  dis_cfg_if.sink   cfg_i
);

  dis_pkg::cfg_t    cfg;
  dis_pkg::item_t   item_q;
  logic             item_valid_q;
  dis_pkg::state_t  state_q;
  dis_pkg::state_t  state_d;
  dis_pkg::result_t res_q;
  dis_pkg::result_t res_d;
  logic             out_valid_q;
  logic             advance;

  // configuration registers
  dis_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // step logic between input and output registers
  dis_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // flow control
  assign advance    = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode       <= dis_pkg::opcode_e'(in_i.opcode);
      item_q.now_ms       <= in_i.now_ms;
      item_q.ready_ack    <= in_i.ready_ack;
      item_q.transmit_ack <= in_i.transmit_ack;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= dis_pkg::PhReady;
      state_q.phase_start_ms <= 32'd0;
      state_q.last_send_ms   <= 32'd0;
      state_q.undisable_sent <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.send_valid    = res_q.send_valid;
  assign out_o.cmd_register  = res_q.cmd_register;
  assign out_o.cmd_data_low  = res_q.cmd_data_low;
  assign out_o.cmd_data_high = res_q.cmd_data_high;
  assign out_o.initialized   = res_q.initialized;
  assign out_o.failed        = res_q.failed;
  assign out_o.phase_now     = res_q.phase_now;

  // checks
  `DIS_ASSERT_NEXT(a_adv_gives_result, clk_i, rst_ni, advance, out_valid_q)
  `DIS_ASSERT(a_idle_frame_zero, clk_i, rst_ni,
    (out_valid_q && !res_q.send_valid) |-> (res_q.cmd_register == 8'd0 &&
    res_q.cmd_data_low == 8'd0 && res_q.cmd_data_high == 8'd0))
  `DIS_ASSERT(a_failed_matches, clk_i, rst_ni,
    out_valid_q |-> (res_q.failed == (res_q.phase_now == dis_pkg::PhError)))
  `DIS_ASSERT(a_init_in_done, clk_i, rst_ni,
    (out_valid_q && res_q.initialized) |-> (res_q.phase_now == dis_pkg::PhDone))
  `DIS_ASSERT_NEXT(a_error_sticky, clk_i, rst_ni,
    (state_q.phase == dis_pkg::PhError &&
    !(advance && item_q.opcode == dis_pkg::OpRestart)),
    (state_q.phase == dis_pkg::PhError))

endmodule
`default_nettype wire

>>> tb/sv/drive_init_sequencer_unit_tb.sv
// self-checking testbench for the drive start-up sequencer
module drive_init_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dis_pkg::*;

  // one directed step with an optional hand-written expectation
  typedef struct {
    opcode_e     op;
    logic [31:0] now;
    logic        rdy;
    logic        txa;
    bit          typed;
    result_t     exp;
  } tick_row_t;

  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 150;
  localparam int PhaseItems  = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  dis_in_if  in_ch ();
  dis_out_if out_ch ();
  dis_cfg_if cfg_ch ();

  drive_init_sequencer_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // predicted sequencer state and register copies
  phase_e      seq_phase;
  logic [31:0] seq_phase_start;
  logic [31:0] seq_last_send;
  logic        seq_undisable;
  logic [15:0] interval_cfg;
  logic [15:0] timeout_cfg;

  result_t     pending_results[$];
  result_t     oldest;
  int unsigned mismatches = 0;

  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  bit          long_hold_due = 1'b0;
  logic [31:0] tick_ms;
  tick_row_t   directed[24];

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // command frame helper
  function automatic result_t command_frame(logic [7:0] rg, logic [7:0] lo, logic [7:0] hi);
    result_t r;
    r = '0;
    r.send_valid    = 1'b1;
    r.cmd_register  = rg;
    r.cmd_data_low  = lo;
    r.cmd_data_high = hi;
    return r;
  endfunction

  // hand-written expectation for the directed table
  function automatic result_t expect_out(bit sv, logic [7:0] rg, logic [7:0] lo,
                                         logic [7:0] hi, bit init, phase_e ph);
    result_t r;
    r.send_valid    = sv;
    r.cmd_register  = rg;
    r.cmd_data_low  = lo;
    r.cmd_data_high = hi;
    r.initialized   = init;
    r.failed        = (ph == PhError);
    r.phase_now     = ph;
    return r;
  endfunction

  // start-up sequence predictor: one step per item
  function automatic result_t advance_sequence(item_t it);
    result_t     r;
    logic [31:0] since_send;
    logic [31:0] since_start;
    logic        init;
    r = '0;
    init = 1'b0;
    since_send  = it.now_ms - seq_last_send;
    since_start = it.now_ms - seq_phase_start;
    if (it.opcode == OpRestart) begin
      seq_phase       = PhReady;
      seq_phase_start = it.now_ms;
      seq_last_send   = '0;
      seq_undisable   = 1'b0;
    end else begin
      case (seq_phase)
        PhReady: begin
          if (since_send >= {16'h0, interval_cfg}) begin
            r = command_frame(CmdRegRead, RdReadyStatus, 8'h00);
            seq_last_send = it.now_ms;
          end
          if (it.ready_ack) begin
            seq_phase     = PhDisable;
            seq_undisable = 1'b0;
          end else if (since_start >= {16'h0, timeout_cfg}) begin
            seq_phase = PhError;
          end
        end
        PhDisable: begin
          r = command_frame(CmdRegMode, ModeDisable, 8'h00);
          seq_phase = PhTx;
        end
        PhTx: begin
          if (since_send >= {16'h0, interval_cfg}) begin
            r = command_frame(CmdRegRead, RdTxEnable, 8'h00);
            seq_last_send = it.now_ms;
          end
          // the timeout still counts from the ready poll start
          if (it.transmit_ack) begin
            seq_phase       = PhUndisable;
            seq_undisable   = 1'b0;
            seq_phase_start = it.now_ms;
            seq_last_send   = it.now_ms;
          end else if (since_start >= {16'h0, timeout_cfg}) begin
            seq_phase = PhError;
          end
        end
        PhUndisable: begin
          if (!seq_undisable) begin
            r = command_frame(CmdRegMode, 8'h00, 8'h00);
            seq_undisable = 1'b1;
            seq_phase     = PhAcc;
          end
        end
        PhAcc: begin
          r = command_frame(CmdRegAcc, AccRampLow, AccRampHigh);
          seq_phase = PhDec;
        end
        PhDec: begin
          r = command_frame(CmdRegDec, DecRampLow, DecRampHigh);
          seq_phase = PhClear;
        end
        PhClear: begin
          r = command_frame(CmdRegClearErr, 8'h00, 8'h00);
          seq_phase = PhDone;
        end
        PhDone: init = 1'b1;
        PhError: ;
        default: seq_phase = PhError;
      endcase
    end
    r.initialized = init;
    r.failed      = (seq_phase == PhError);
    r.phase_now   = seq_phase;
    return r;
  endfunction

  // offer one item, predict its result once accepted
  task automatic offer_tick(item_t it, bit typed, result_t typed_exp);
    result_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.opcode;
    in_ch.now_ms       <= it.now_ms;
    in_ch.ready_ack    <= it.ready_ack;
    in_ch.transmit_ack <= it.transmit_ack;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = advance_sequence(it);
    pending_results.push_back(typed ? typed_exp : predicted);
  endtask

  // register write, valid left high for a following write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == CfgActionInterval) interval_cfg = val;
    else if (idx == CfgTimeout) timeout_cfg = val;
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly coherent time with acks, restarts and the odd time jump
  task automatic run_random(int count, bit with_hold);
    item_t       it;
    int unsigned span;
    int          k;
    span = (interval_cfg >> 1) + (timeout_cfg >> 5) + 2;
    for (k = 0; k < count; k++) begin
      if (with_hold && k == count / 4) long_hold_due <= 1'b1;
      it.opcode       = OpStep;
      it.ready_ack    = ($urandom_range(99) < 12);
      it.transmit_ack = ($urandom_range(99) < 12);
      if ((seq_phase == PhError && $urandom_range(1) == 1) ||
          (seq_phase == PhDone && $urandom_range(3) == 0) || $urandom_range(99) < 2) begin
        it.opcode = OpRestart;
        if ($urandom_range(1) == 1) tick_ms = $urandom;
      end else if ($urandom_range(99) < 3) begin
        tick_ms = $urandom;
      end else begin
        tick_ms = tick_ms + $urandom_range(span);
      end
      it.now_ms = tick_ms;
      offer_tick(it, 1'b0, '0);
    end
  endtask

  // one setting of the registers and of the idling
  task automatic run_phase(logic [15:0] interval, logic [15:0] limit_ms, int gap, int stall,
                           bit with_hold);
    drain();
    write_reg(CfgActionInterval, interval);
    write_reg(CfgTimeout, limit_ms);
    cfg_ch.valid   <= 1'b0;
    send_gap_pct    = gap;
    recv_stall_pct <= stall;
    run_random(PhaseItems, with_hold);
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_due && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual phase %0d", $time,
                 out_ch.phase_now);
      end else begin
        oldest = pending_results.pop_front();
        compare_field("send_valid", oldest.send_valid, out_ch.send_valid);
        compare_field("cmd_register", oldest.cmd_register, out_ch.cmd_register);
        compare_field("cmd_data_low", oldest.cmd_data_low, out_ch.cmd_data_low);
        compare_field("cmd_data_high", oldest.cmd_data_high, out_ch.cmd_data_high);
        compare_field("initialized", oldest.initialized, out_ch.initialized);
        compare_field("failed", oldest.failed, out_ch.failed);
        compare_field("phase_now", oldest.phase_now, out_ch.phase_now);
      end
    end
  end

  // run time limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // main sequence
  initial begin
    item_t it;
    int    k;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OpStep;
    in_ch.now_ms       = '0;
    in_ch.ready_ack    = 1'b0;
    in_ch.transmit_ack = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CfgActionInterval;
    cfg_ch.data        = '0;
    seq_phase          = PhReady;
    seq_phase_start    = '0;
    seq_last_send      = '0;
    seq_undisable      = 1'b0;
    interval_cfg       = ActionIntervalRst;
    timeout_cfg        = TimeoutRst;
    tick_ms            = '0;

    // walk through poll, timeout, wrap-around, the full start-up and restart
    directed = '{
      '{OpStep,    32'd0,          1'b0, 1'b0, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 0, PhReady)},
      '{OpStep,    32'd101,        1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegRead, RdReadyStatus, 8'h00, 0, PhReady)},
      '{OpStep,    32'd150,        1'b0, 1'b0, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 0, PhReady)},
      '{OpStep,    32'd2000,       1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegRead, RdReadyStatus, 8'h00, 0, PhError)},
      '{OpStep,    32'd2100,       1'b1, 1'b1, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 0, PhError)},
      '{OpRestart, 32'hFFFF_FF00,  1'b1, 1'b1, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 0, PhReady)},
      '{OpStep,    32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, '0},
      '{OpStep,    32'h0000_0010,  1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegMode, ModeDisable, 8'h00, 0, PhTx)},
      '{OpStep,    32'h0000_0020,  1'b0, 1'b0, 1'b0, '0},
      '{OpStep,    32'h0000_0080,  1'b0, 1'b0, 1'b0, '0},
      '{OpStep,    32'h0000_0090,  1'b1, 1'b1, 1'b0, '0},
      '{OpStep,    32'h0000_0095,  1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegMode, 8'h00, 8'h00, 0, PhAcc)},
      '{OpStep,    32'h0000_0096,  1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegAcc, AccRampLow, AccRampHigh, 0, PhDec)},
      '{OpStep,    32'h0000_0097,  1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegDec, DecRampLow, DecRampHigh, 0, PhClear)},
      '{OpStep,    32'h0000_0098,  1'b0, 1'b0, 1'b1,
        expect_out(1, CmdRegClearErr, 8'h00, 8'h00, 0, PhDone)},
      '{OpStep,    32'h0000_0200,  1'b0, 1'b0, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 1, PhDone)},
      '{OpStep,    32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 1, PhDone)},
      '{OpRestart, 32'd1000,       1'b0, 1'b0, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 0, PhReady)},
      '{OpStep,    32'd1100,       1'b1, 1'b0, 1'b0, '0},
      '{OpStep,    32'd1200,       1'b0, 1'b0, 1'b0, '0},
      // transmission timeout counted from the restart
      '{OpStep,    32'd3000,       1'b0, 1'b0, 1'b0, '0},
      '{OpRestart, 32'd0,          1'b0, 1'b0, 1'b1,
        expect_out(0, 8'h00, 8'h00, 8'h00, 0, PhReady)},
      // ready seen on a tick too early for a poll
      '{OpStep,    32'd50,         1'b1, 1'b0, 1'b0, '0},
      '{OpStep,    32'd60,         1'b0, 1'b0, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < $size(directed); k++) begin
      it.opcode       = directed[k].op;
      it.now_ms       = directed[k].now;
      it.ready_ack    = directed[k].rdy;
      it.transmit_ack = directed[k].txa;
      offer_tick(it, directed[k].typed, directed[k].exp);
    end

    // sender idles lightly, receiver heavily
    run_phase(ActionIntervalRst, TimeoutRst, 10, 45, 1'b1);
    run_phase(16'd0, 16'hFFFF, 10, 45, 1'b0);
    // the other way round
    run_phase(16'hFFFF, 16'hFFFF, 45, 10, 1'b0);
    run_phase(16'd0, 16'd0, 45, 10, 1'b0);
    // no idling
    run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)), 0, 0, 1'b0);
    run_phase(16'd37, 16'd600, 0, 0, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dis_pkg.sv
rtl/core/dis_if.sv
rtl/core/dis_cfg.sv
rtl/core/dis_step.sv
rtl/core/drive_init_sequencer_unit.sv
tb/sv/drive_init_sequencer_unit_tb.sv
